// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define TCM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/tcm_pkg.sv
// Package: widths, screen constants and word types of the touch calibration mapper.
`default_nettype none
package tcm_pkg;

  localparam int RAW_W   = 12;
  localparam int SPAN_W  = 13;
  localparam int COORD_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // Product magnitude |raw - centre| * size stays below 2^22.
  localparam int PROD_W = 22;
  // Remainder is below the divisor, which is at most 4096.
  localparam int REM_W  = 13;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [COORD_W-1:0] SCREEN_W = 10'd800;
  localparam logic [COORD_W-1:0] SCREEN_H = 10'd480;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y    = 3'd4;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
  } out_word_t;

  // One axis in flight: remainder and dividend/quotient share one shift register.
  typedef struct packed {
    logic [REM_W+PROD_W-1:0] rq;
    logic [REM_W-1:0]        dsr;
    logic                    neg;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/touch_calibration_mapper.sv
// Top level: linear touchscreen calibration pipeline from raw sample to pixel word.
// Takes one raw sample word per cycle while in_stall is low and returns one screen word per
// sample: one front stage (swap, offset and scale by screen size), a chain of 22 divider
// cells that each settle one quotient bit of the signed truncating divide by span, and one
// output register that restores the sign, adds half the screen size and clamps. A zero span
// divides by one. Stalls ripple back through the chain so that empty cells keep filling while
// the output word waits. Calibration registers are written through the config port, always
// ready; the user writes them only while no sample is in flight (the block does not check).
`default_nettype none
module touch_calibration_mapper (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tcm_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tcm_pkg::out_word_t                  out_data
);

  logic            cell_valid [tcm_pkg::DIV_STEPS+1];
  tcm_pkg::stage_t cell_data  [tcm_pkg::DIV_STEPS+1];
  logic            cell_ready [tcm_pkg::DIV_STEPS+1];

  tcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .down_ready (cell_ready[0]),
    .valid      (cell_valid[0]),
    .data       (cell_data[0])
  );

  // Chain of divider cells, one quotient bit each.
  for (genvar i = 0; i < tcm_pkg::DIV_STEPS; i++) begin : g_cell
    tcm_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (cell_valid[i]),
      .up_data    (cell_data[i]),
      .ready      (cell_ready[i]),
      .down_ready (cell_ready[i+1]),
      .valid      (cell_valid[i+1]),
      .data       (cell_data[i+1])
    );
  end

  tcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (cell_valid[tcm_pkg::DIV_STEPS]),
    .up_data   (cell_data[tcm_pkg::DIV_STEPS]),
    .ready     (cell_ready[tcm_pkg::DIV_STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/tcm_front.sv
// Front stage: calibration registers, axis swap, offset, scale and sign split.
`default_nettype none
module tcm_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tcm_pkg::in_word_t              in_data,
  input  wire logic                           down_ready,
  output logic                                valid,
  output tcm_pkg::stage_t                     data
);

  logic                              swap_axes;
  logic [tcm_pkg::RAW_W-1:0]         centre_x;
  logic [tcm_pkg::RAW_W-1:0]         centre_y;
  logic signed [tcm_pkg::SPAN_W-1:0] span_x;
  logic signed [tcm_pkg::SPAN_W-1:0] span_y;
  logic                              ready;
  logic [tcm_pkg::RAW_W-1:0]         ax;
  logic [tcm_pkg::RAW_W-1:0]         ay;

  // Split one axis into product magnitude, divisor magnitude and result sign.
  function automatic tcm_pkg::axis_t prep(
    input logic [tcm_pkg::RAW_W-1:0]         raw,
    input logic [tcm_pkg::RAW_W-1:0]         centre,
    input logic signed [tcm_pkg::SPAN_W-1:0] span,
    input logic [tcm_pkg::COORD_W-1:0]       size
  );
    logic signed [tcm_pkg::RAW_W:0] diff;
    logic [tcm_pkg::RAW_W-1:0]      mag;
    tcm_pkg::axis_t                 a;
    diff = $signed({1'b0, raw}) - $signed({1'b0, centre});
    mag  = diff[tcm_pkg::RAW_W] ? tcm_pkg::RAW_W'(-diff) : diff[tcm_pkg::RAW_W-1:0];
    if (span == '0) begin
      a.dsr = tcm_pkg::REM_W'(1);
    end else if (span[tcm_pkg::SPAN_W-1]) begin
      a.dsr = tcm_pkg::REM_W'(-span);
    end else begin
      a.dsr = tcm_pkg::REM_W'(span);
    end
    a.rq  = {{tcm_pkg::REM_W{1'b0}},
             tcm_pkg::PROD_W'(mag) * tcm_pkg::PROD_W'(size)};
    a.neg = diff[tcm_pkg::RAW_W] ^ span[tcm_pkg::SPAN_W-1];
    return a;
  endfunction

  assign cfg_ready = 1'b1;
  assign ready     = !valid || down_ready;
  assign in_stall  = valid && !down_ready;

  // Exchange raw readings when the swap mode is on.
  assign ax = swap_axes ? in_data.raw_y : in_data.raw_x;
  assign ay = swap_axes ? in_data.raw_x : in_data.raw_y;

  // Hold calibration registers; the user writes only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_axes <= 1'b0;
      centre_x  <= 12'd2048;
      centre_y  <= 12'd2048;
      span_x    <= 13'sd4095;
      span_y    <= 13'sd4095;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcm_pkg::REG_SWAP_AXES: swap_axes <= cfg_data[0];
        tcm_pkg::REG_CENTRE_X:  centre_x  <= cfg_data[tcm_pkg::RAW_W-1:0];
        tcm_pkg::REG_CENTRE_Y:  centre_y  <= cfg_data[tcm_pkg::RAW_W-1:0];
        tcm_pkg::REG_SPAN_X:    span_x    <= $signed(cfg_data[tcm_pkg::SPAN_W-1:0]);
        tcm_pkg::REG_SPAN_Y:    span_y    <= $signed(cfg_data[tcm_pkg::SPAN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Advance the front register when the first divider cell can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      data.x <= prep(ax, centre_x, span_x, tcm_pkg::SCREEN_W);
      data.y <= prep(ay, centre_y, span_y, tcm_pkg::SCREEN_H);
    end
  end

endmodule
`default_nettype wire

// File: rtl/tcm_div_cell.sv
// Divider cell: one restoring quotient bit for both axes per pipeline step.
`default_nettype none
module tcm_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  input  wire tcm_pkg::stage_t up_data,
  output logic                 ready,
  input  wire logic            down_ready,
  output logic                 valid,
  output tcm_pkg::stage_t      data
);

  // Shift in the next dividend bit and subtract the divisor when it fits.
  function automatic tcm_pkg::axis_t step(input tcm_pkg::axis_t a);
    logic [tcm_pkg::REM_W+tcm_pkg::PROD_W-1:0] t;
    logic [tcm_pkg::REM_W-1:0]                 top;
    tcm_pkg::axis_t                            r;
    t   = {a.rq[tcm_pkg::REM_W+tcm_pkg::PROD_W-2:0], 1'b0};
    top = t[tcm_pkg::REM_W+tcm_pkg::PROD_W-1:tcm_pkg::PROD_W];
    if (top >= a.dsr) begin
      t[tcm_pkg::REM_W+tcm_pkg::PROD_W-1:tcm_pkg::PROD_W] = top - a.dsr;
      t[0] = 1'b1;
    end
    r     = a;
    r.rq  = t;
    return r;
  endfunction

  assign ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      data.x <= step(up_data.x);
      data.y <= step(up_data.y);
    end
  end

endmodule
`default_nettype wire

// File: rtl/tcm_back.sv
// Output stage: restore sign, add the half-screen offset, clamp and register the word.
`default_nettype none
module tcm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  input  wire tcm_pkg::stage_t   up_data,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tcm_pkg::out_word_t     out_data
);

  // Signed quotient plus offset, then clamp to 0..size.
  function automatic logic [tcm_pkg::COORD_W-1:0] finish(
    input tcm_pkg::axis_t              a,
    input logic [tcm_pkg::COORD_W-1:0] size
  );
    logic signed [tcm_pkg::PROD_W+1:0] q;
    logic signed [tcm_pkg::PROD_W+1:0] v;
    logic signed [tcm_pkg::PROD_W+1:0] lim;
    q   = $signed({2'b00, a.rq[tcm_pkg::PROD_W-1:0]});
    lim = $signed({{(tcm_pkg::PROD_W-tcm_pkg::COORD_W+2){1'b0}}, size});
    v   = (a.neg ? -q : q) + (lim >>> 1);
    if (v < 0) begin
      return '0;
    end else if (v > lim) begin
      return size;
    end
    return v[tcm_pkg::COORD_W-1:0];
  endfunction

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      out_data.screen_x <= finish(up_data.x, tcm_pkg::SCREEN_W);
      out_data.screen_y <= finish(up_data.y, tcm_pkg::SCREEN_H);
    end
  end

endmodule
`default_nettype wire

// File: rtl/tcm_checker.sv
// Port-level checks for the touch calibration mapper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tcm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tcm_pkg::out_word_t out_data
);

  // Hold a stalled output word.
  `TCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output word changed")

  // Clamp keeps columns and rows on the screen.
  `TCM_ASSERT(a_x_range, !out_valid || (out_data.screen_x <= tcm_pkg::SCREEN_W), "screen_x above width")
  `TCM_ASSERT(a_y_range, !out_valid || (out_data.screen_y <= tcm_pkg::SCREEN_H), "screen_y above height")

  // With the output register empty, the whole chain can advance.
  `TCM_ASSERT(a_no_false_stall, out_valid || !in_stall, "input stalled with output empty")

endmodule

bind touch_calibration_mapper tcm_checker u_tcm_checker (.*);
`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for the touch calibration mapper: directed, random and back-pressure runs.
`timescale 1ns / 1ps
module testbench;

  localparam int RESET_CYCLES      = 10;
  localparam int PIPE_LATENCY      = 24;
  localparam int CYCLE_LIMIT       = 200000;
  localparam int HOLD_CYCLES       = 200;
  localparam int ITEMS_PER_SETTING = 83;
  localparam int PRESSURE_ITEMS    = 80;
  localparam logic [tcm_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = tcm_pkg::REG_SPAN_Y + 3'd1;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tcm_pkg::in_word_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tcm_pkg::out_word_t             out_data;

  // Bench copy of the calibration registers, reset values included
  logic                              swap_reg = 1'b0;
  logic [tcm_pkg::RAW_W-1:0]         centre_x_reg = 12'd2048;
  logic [tcm_pkg::RAW_W-1:0]         centre_y_reg = 12'd2048;
  logic signed [tcm_pkg::SPAN_W-1:0] span_x_reg = 13'sd4095;
  logic signed [tcm_pkg::SPAN_W-1:0] span_y_reg = 13'sd4095;

  tcm_pkg::out_word_t pending_screen[$];
  tcm_pkg::out_word_t want;
  int                 fail_count = 0;
  int unsigned        cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  logic               long_hold = 1'b0;

  touch_calibration_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the output at random, or hold it off for the long stretch
  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Map one axis: offset from centre, scale by size over span, recentre, clamp
  function automatic logic [tcm_pkg::COORD_W-1:0] scale_axis(
    input logic [tcm_pkg::RAW_W-1:0]         raw,
    input logic [tcm_pkg::RAW_W-1:0]         centre,
    input logic signed [tcm_pkg::SPAN_W-1:0] span,
    input int                                size
  );
    int divisor;
    int offset;
    int pixel;
    divisor = (span == 0) ? 1 : int'(span);
    offset = int'(raw) - int'(centre);
    pixel = offset * size / divisor + size / 2;
    if (pixel < 0) begin
      pixel = 0;
    end else if (pixel > size) begin
      pixel = size;
    end
    return pixel[tcm_pkg::COORD_W-1:0];
  endfunction

  function automatic tcm_pkg::out_word_t predict_screen(input tcm_pkg::in_word_t w);
    tcm_pkg::out_word_t        r;
    logic [tcm_pkg::RAW_W-1:0] ax;
    logic [tcm_pkg::RAW_W-1:0] ay;
    ax = swap_reg ? w.raw_y : w.raw_x;
    ay = swap_reg ? w.raw_x : w.raw_y;
    r.screen_x = scale_axis(ax, centre_x_reg, span_x_reg, int'(tcm_pkg::SCREEN_W));
    r.screen_y = scale_axis(ay, centre_y_reg, span_y_reg, int'(tcm_pkg::SCREEN_H));
    return r;
  endfunction

  // Compare each accepted screen word with the oldest prediction
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_screen.size() == 0) begin
        $error("unexpected screen word x=%0d y=%0d", out_data.screen_x, out_data.screen_y);
        fail_count++;
      end else begin
        want = pending_screen.pop_front();
        if (out_data.screen_x !== want.screen_x) begin
          $error("screen_x mismatch: expected %0d, actual %0d", want.screen_x, out_data.screen_x);
          fail_count++;
        end
        if (out_data.screen_y !== want.screen_y) begin
          $error("screen_y mismatch: expected %0d, actual %0d", want.screen_y, out_data.screen_y);
          fail_count++;
        end
      end
    end
  end

  // Offer one raw word after a random gap; record the prediction on acceptance
  task automatic send_sample(input tcm_pkg::in_word_t w);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(negedge clk);
      took = !in_stall;
      if (took) begin
        pending_screen.push_back(predict_screen(w));
      end
      @(posedge clk);
    end while (!took);
  endtask

  function automatic tcm_pkg::in_word_t raw_word(input int x, input int y);
    tcm_pkg::in_word_t w;
    w.raw_x = x[tcm_pkg::RAW_W-1:0];
    w.raw_y = y[tcm_pkg::RAW_W-1:0];
    return w;
  endfunction

  // Drop valid and wait for every predicted word to come back
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_screen.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Write one register and mirror it in the bench copy
  task automatic write_reg(input logic [tcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcm_pkg::CFG_DATA_W-1:0] value);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      tcm_pkg::REG_SWAP_AXES: swap_reg = value[0];
      tcm_pkg::REG_CENTRE_X:  centre_x_reg = value[tcm_pkg::RAW_W-1:0];
      tcm_pkg::REG_CENTRE_Y:  centre_y_reg = value[tcm_pkg::RAW_W-1:0];
      tcm_pkg::REG_SPAN_X:    span_x_reg = value;
      tcm_pkg::REG_SPAN_Y:    span_y_reg = value;
      default: ;
    endcase
  endtask

  task automatic end_config();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic swap,
                                input logic [tcm_pkg::RAW_W-1:0] cx,
                                input logic [tcm_pkg::RAW_W-1:0] cy,
                                input logic signed [tcm_pkg::SPAN_W-1:0] sx,
                                input logic signed [tcm_pkg::SPAN_W-1:0] sy);
    write_reg(tcm_pkg::REG_SWAP_AXES, {12'd0, swap});
    write_reg(tcm_pkg::REG_CENTRE_X, {1'b0, cx});
    write_reg(tcm_pkg::REG_CENTRE_Y, {1'b0, cy});
    write_reg(tcm_pkg::REG_SPAN_X, sx);
    write_reg(tcm_pkg::REG_SPAN_Y, sy);
    end_config();
  endtask

  function automatic logic signed [tcm_pkg::SPAN_W-1:0] random_span();
    logic signed [tcm_pkg::SPAN_W-1:0] s;
    case ($urandom_range(3))
      0: s = tcm_pkg::SPAN_W'($urandom);
      1: s = tcm_pkg::SPAN_W'($urandom_range(16));
      2: s = -tcm_pkg::SPAN_W'($urandom_range(16));
      default: s = tcm_pkg::SPAN_W'($urandom_range(1024, 4095));
    endcase
    if ($urandom_range(1)) begin
      s = -s;
    end
    return s;
  endfunction

  // Extremes for the first setting of a phase, random ones otherwise
  task automatic pick_settings(input int pick);
    case (pick)
      0: apply_settings(1'b1, 12'd0, 12'd4095, -13'sd4096, 13'sd4095);
      1: apply_settings(1'b0, 12'd4095, 12'd0, 13'sd4095, -13'sd4096);
      2: apply_settings(1'b1, 12'd2048, 12'd2048, 13'sd1, -13'sd1);
      default: apply_settings(1'($urandom_range(1)), 12'($urandom), 12'($urandom),
                             random_span(), random_span());
    endcase
  endtask

  function automatic logic [tcm_pkg::RAW_W-1:0] near_value(input logic [tcm_pkg::RAW_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(128)) - 64;
    if (v < 0) begin
      v = 0;
    end else if (v > 4095) begin
      v = 4095;
    end
    return v[tcm_pkg::RAW_W-1:0];
  endfunction

  // Mix samples near the centres, at the rails and anywhere
  function automatic tcm_pkg::in_word_t random_sample();
    tcm_pkg::in_word_t w;
    case ($urandom_range(3))
      0: begin
        w.raw_x = near_value(swap_reg ? centre_y_reg : centre_x_reg);
        w.raw_y = near_value(swap_reg ? centre_x_reg : centre_y_reg);
      end
      1: begin
        w.raw_x = $urandom_range(1) ? 12'hFFF : 12'h000;
        w.raw_y = $urandom_range(1) ? 12'hFFF : 12'($urandom);
      end
      default: begin
        w.raw_x = 12'($urandom);
        w.raw_y = 12'($urandom);
      end
    endcase
    return w;
  endfunction

  task automatic test_reset_values();
    send_sample(raw_word(0, 0));
    send_sample(raw_word(4095, 4095));
    send_sample(raw_word(2048, 2048));
    send_sample(raw_word(0, 4095));
    send_sample(raw_word(4095, 0));
    quiesce();
  endtask

  task automatic test_swap_axes();
    apply_settings(1'b1, 12'd1000, 12'd3000, 13'sd2000, 13'sd1500);
    send_sample(raw_word(100, 3900));
    send_sample(raw_word(3900, 100));
    send_sample(raw_word(3000, 1000));
    quiesce();
  endtask

  // Zero span divides by one, so any offset lands on a rail
  task automatic test_zero_span();
    apply_settings(1'b0, 12'd2048, 12'd2048, 13'sd0, 13'sd0);
    send_sample(raw_word(2048, 2048));
    send_sample(raw_word(2049, 2047));
    send_sample(raw_word(2047, 2049));
    quiesce();
  endtask

  // Mirror the axes and check truncation toward zero
  task automatic test_negative_span();
    apply_settings(1'b0, 12'd2048, 12'd2048, -13'sd4096, -13'sd1);
    send_sample(raw_word(0, 2048));
    send_sample(raw_word(4095, 2049));
    send_sample(raw_word(1000, 2047));
    quiesce();
    apply_settings(1'b0, 12'd2048, 12'd2048, -13'sd3, 13'sd7);
    send_sample(raw_word(2049, 2049));
    send_sample(raw_word(2047, 2047));
    quiesce();
  endtask

  // Writes past the last register must leave the settings alone
  task automatic test_unused_index();
    apply_settings(1'b0, 12'd1500, 12'd2500, 13'sd3000, 13'sd2500);
    for (int i = int'(REG_UNUSED_FIRST); i < 2 ** tcm_pkg::CFG_IDX_W; i++) begin
      write_reg(i[tcm_pkg::CFG_IDX_W-1:0], '1);
    end
    end_config();
    send_sample(raw_word(1700, 2300));
    send_sample(raw_word(1300, 2700));
    quiesce();
  endtask

  // Excess data bits on narrow registers are masked off
  task automatic test_field_masking();
    write_reg(tcm_pkg::REG_SWAP_AXES, 13'h1FFE);
    write_reg(tcm_pkg::REG_CENTRE_X, 13'h1ABC);
    write_reg(tcm_pkg::REG_CENTRE_Y, 13'h1123);
    end_config();
    send_sample(raw_word('hABC, 'h200));
    send_sample(raw_word('hC00, 'h123));
    quiesce();
    write_reg(tcm_pkg::REG_SWAP_AXES, 13'h1FF3);
    end_config();
    send_sample(raw_word('h100, 'hE00));
    quiesce();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int extreme_pick);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 3; s++) begin
      pick_settings(s == 0 ? extreme_pick : 3);
      repeat (ITEMS_PER_SETTING) begin
        send_sample(random_sample());
      end
      quiesce();
    end
  endtask

  // Hold the output off long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pick_settings(3);
    fork
      begin
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    repeat (PRESSURE_ITEMS) begin
      send_sample(random_sample());
    end
    quiesce();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 45;
    test_reset_values();
    test_swap_axes();
    test_zero_span();
    test_negative_span();
    test_unused_index();
    test_field_masking();
    test_random(33, 45, 0);
    test_random(45, 33, 1);
    test_random(0, 0, 2);
    test_backpressure();
    quiesce();
    // Catch stray words after the last expected one
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: touch_calibration_mapper.f
+incdir+rtl
rtl/tcm_pkg.sv
rtl/tcm_front.sv
rtl/tcm_div_cell.sv
rtl/tcm_back.sv
rtl/touch_calibration_mapper.sv
rtl/tcm_checker.sv
test/testbench.sv
